/* rtl/core/mhcs_pkg.sv */
// ----------------------------------------------------------------------------
// mhcs_pkg
// Shared types, constants and the prefix table of the mail header splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package mhcs_pkg;

    // hold buffer, prefix and command queue sizes
    localparam int HOLD_DEPTH      = 12;
    localparam int CONTENT_LEN     = 8;
    localparam int CMDQ_DEPTH      = 4;
    localparam int HOLD_IDX_W      = $clog2(HOLD_DEPTH + 1);
    localparam int CMDQ_PTR_W      = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W      = $clog2(CMDQ_DEPTH + 1);

    // class codes
    localparam logic [1:0] CLS_MESSAGE = 2'd0;
    localparam logic [1:0] CLS_CONTENT = 2'd1;
    localparam logic [1:0] CLS_TYPE    = 2'd2;

    // special bytes
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;

    // input word
    typedef struct packed {
        logic [7:0] ch;
        logic       final_req;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [7:0] out_ch;
        logic [1:0] dest;
        logic       run_end;
    } out_word_t;

    // command from front end to back end
    typedef struct packed {
        logic [7:0]            ch;
        logic [1:0]            cls;
        logic                  hold;     // store ch in the hold buffer at idx
        logic [HOLD_IDX_W-1:0] idx;
        logic [HOLD_IDX_W-1:0] cnt;      // held bytes to send
        logic                  send_ch;  // send ch after the held bytes
    } cmd_t;

    // lower-case "content-type" without the colon
    function automatic logic [7:0] prefix_char(input logic [HOLD_IDX_W-1:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h63;  // c
            4'd1:    c = 8'h6f;  // o
            4'd2:    c = 8'h6e;  // n
            4'd3:    c = 8'h74;  // t
            4'd4:    c = 8'h65;  // e
            4'd5:    c = 8'h6e;  // n
            4'd6:    c = 8'h74;  // t
            4'd7:    c = 8'h2d;  // -
            4'd8:    c = 8'h74;  // t
            4'd9:    c = 8'h79;  // y
            4'd10:   c = 8'h70;  // p
            4'd11:   c = 8'h65;  // e
            default: c = CH_COLON;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mhcs_front.sv */
// ----------------------------------------------------------------------------
// mhcs_front
// Tracks header boundaries and the prefix match, and issues one command per
// accepted input word.
// ----------------------------------------------------------------------------
`default_nettype none

module mhcs_front
    import mhcs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_word_t din,
    output cmd_t          cmd
);

    logic [HOLD_IDX_W-1:0] match_count_reg, match_count_next;
    logic                  decided_reg, decided_next;
    logic [1:0]            cls_reg, cls_next;
    logic                  after_nl_reg, after_nl_next;
    logic                  at_start_reg, at_start_next;

    logic                  continues;
    logic                  start;
    logic [HOLD_IDX_W-1:0] p;
    logic                  eff_decided;
    logic [1:0]            eff_cls;
    logic [7:0]            folded;
    logic [HOLD_IDX_W-1:0] held_after;

    // header boundary and case folding
    always_comb
    begin
        continues   = (din.ch == CH_SPACE) || (din.ch == CH_TAB) || (din.ch == CH_LF);
        start       = at_start_reg || (after_nl_reg && !continues);
        p           = start ? '0 : match_count_reg;
        eff_decided = start ? 1'b0 : decided_reg;
        eff_cls     = start ? CLS_MESSAGE : cls_reg;
        folded      = ((din.ch >= 8'h41) && (din.ch <= 8'h5a)) ? (din.ch + 8'd32) : din.ch;
        held_after  = p + 1'b1;
    end

    // classification and command build
    always_comb
    begin
        cmd              = '0;
        cmd.ch           = din.ch;
        match_count_next = p;
        decided_next     = eff_decided;
        cls_next         = eff_cls;
        after_nl_next    = (din.ch == CH_CR) || (din.ch == CH_LF);
        at_start_next    = 1'b0;

        priority if (eff_decided)
        begin
            cmd.cls     = eff_cls;
            cmd.send_ch = 1'b1;
        end
        else if ((p < HOLD_IDX_W'(HOLD_DEPTH)) && (folded == prefix_char(p)))
        begin
            cmd.hold         = 1'b1;
            cmd.idx          = p;
            match_count_next = held_after;
        end
        else if ((p >= HOLD_IDX_W'(HOLD_DEPTH)) && (folded == CH_COLON))
        begin
            cmd.cls          = CLS_TYPE;
            cmd.cnt          = p;
            cmd.send_ch      = 1'b1;
            cls_next         = CLS_TYPE;
            decided_next     = 1'b1;
            match_count_next = '0;
        end
        else
        begin
            cmd.cls          = (p >= HOLD_IDX_W'(CONTENT_LEN)) ? CLS_CONTENT : CLS_MESSAGE;
            cmd.cnt          = p;
            cmd.send_ch      = 1'b1;
            cls_next         = cmd.cls;
            decided_next     = 1'b1;
            match_count_next = '0;
        end

        // final word flushes an undecided header and restarts
        if (din.final_req)
        begin
            if (!decided_next)
            begin
                cmd.cls = (match_count_next >= HOLD_IDX_W'(CONTENT_LEN)) ?
                          CLS_CONTENT : CLS_MESSAGE;
                cmd.cnt = match_count_next;
            end
            match_count_next = '0;
            decided_next     = 1'b0;
            cls_next         = CLS_MESSAGE;
            after_nl_next    = 1'b0;
            at_start_next    = 1'b1;
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_count_reg <= '0;
            decided_reg     <= 1'b0;
            cls_reg         <= CLS_MESSAGE;
            after_nl_reg    <= 1'b0;
            at_start_reg    <= 1'b1;
        end
        else if (accept)
        begin
            match_count_reg <= match_count_next;
            decided_reg     <= decided_next;
            cls_reg         <= cls_next;
            after_nl_reg    <= after_nl_next;
            at_start_reg    <= at_start_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mhcs_cmdq.sv */
// ----------------------------------------------------------------------------
// mhcs_cmdq
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mhcs_cmdq
    import mhcs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_cmd,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_cmd,
    output logic      nonempty
);

    cmd_t                  slot_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;

    // status and read data
    always_comb
    begin
        full        = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
        nonempty    = (count_reg != '0);
        rd_cmd      = slot_reg[rd_ptr_reg];
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CMDQ_CNT_W'(wr_en) - CMDQ_CNT_W'(rd_en);
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mhcs_back.sv */
// ----------------------------------------------------------------------------
// mhcs_back
// Holds undecided bytes and sends each command's words, one per cycle while the
// output register is free or popped, into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhcs_back
    import mhcs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cmd_t cmd,
    input  wire logic cmd_avail,
    output logic      cmd_take,
    output out_word_t dout,
    output logic      empty,
    input  wire logic pop
);

    logic [7:0]            hold_reg [HOLD_DEPTH];
    cmd_t                  cur_reg;
    logic                  busy_reg, busy_next;
    logic [HOLD_IDX_W-1:0] pos_reg, pos_next;
    out_word_t             out_reg;
    logic                  out_valid_reg, out_valid_next;

    logic [HOLD_IDX_W-1:0] total_cur;
    logic [HOLD_IDX_W-1:0] total_new;
    logic                  send;
    logic                  last;
    logic [7:0]            item_ch;

    // sequencing of the current command
    always_comb
    begin
        total_cur = cur_reg.cnt + HOLD_IDX_W'(cur_reg.send_ch);
        total_new = cmd.cnt + HOLD_IDX_W'(cmd.send_ch);
        send      = busy_reg && (!out_valid_reg || pop);
        last      = (pos_reg == total_cur - 1'b1);
        cmd_take  = cmd_avail && (!busy_reg || (send && last));
        if ((pos_reg < cur_reg.cnt) && (pos_reg < HOLD_IDX_W'(HOLD_DEPTH)))
        begin
            item_ch = hold_reg[pos_reg];
        end
        else
        begin
            item_ch = cur_reg.ch;
        end

        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (cmd_take)
        begin
            busy_next = (total_new != '0);
            pos_next  = '0;
        end
        else if (send)
        begin
            busy_next = !last;
            pos_next  = pos_reg + 1'b1;
        end

        out_valid_next = send ? 1'b1 : (pop ? 1'b0 : out_valid_reg);
        empty          = !out_valid_reg;
        dout           = out_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command, hold buffer and output word
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_reg <= cmd;
            if (cmd.hold)
            begin
                hold_reg[cmd.idx] <= cmd.ch;
            end
        end
        if (send)
        begin
            out_reg.out_ch  <= item_ch;
            out_reg.dest    <= cur_reg.cls;
            out_reg.run_end <= last;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/mail_header_class_splitter_core.sv */
// ----------------------------------------------------------------------------
// mail_header_class_splitter_core
// Splits a mail header block into message, content and content-type words.
// ----------------------------------------------------------------------------
// A byte is taken on every cycle in which push is high and full is low; the
// front end classifies it in that cycle and drops a command into a 4-deep
// queue. The back end takes at most one command per cycle, none while still
// busy with the last, and turns it into its result words through a single
// output register at one word per cycle while pop frees it. A command that
// releases n held bytes plus the byte itself sends n+1 words, at most 13. A
// command that only stores a byte in the hold buffer sends nothing but still
// takes a back-end turn, so each held byte, up to the 12 of the prefix, costs
// the back end once when stored and once more when sent. Bytes of a header
// whose class is known go through at one per cycle with pop held high. With
// an idle back end a byte passes the command queue, the current-command
// register and the output register in that order. Input is refused only
// while the command queue is full. No clearing pass is needed after reset.
`default_nettype none

module mail_header_class_splitter_core
    import mhcs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    output logic           full,
    input  wire in_word_t  din,
    input  wire logic      pop,
    output logic           empty,
    output out_word_t      dout
);

    cmd_t front_cmd;
    cmd_t back_cmd;
    logic accept;
    logic cmd_avail;
    logic cmd_take;

    // input word accepted
    assign accept = push && !full;

    // classifier
    mhcs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .din    (din),
        .cmd    (front_cmd)
    );

    // command queue
    mhcs_cmdq u_cmdq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_cmd   (front_cmd),
        .full     (full),
        .rd_en    (cmd_take),
        .rd_cmd   (back_cmd),
        .nonempty (cmd_avail)
    );

    // output sequencer
    mhcs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_avail (cmd_avail),
        .cmd_take  (cmd_take),
        .dout      (dout),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

/* rtl/core/mhcs_checker.sv */
// ----------------------------------------------------------------------------
// mhcs_checker
// Port-level checks on the splitter output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhcs_checker
    import mhcs_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      full,
    input wire logic      pop,
    input wire logic      empty,
    input wire out_word_t dout
);

    // status flags are always driven
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({full, empty}))
        else $error("full or empty unknown");

    // a waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(dout)))
        else $error("result word changed while stalled");

    // only the three class codes appear
    a_dest: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (dout.dest == CLS_MESSAGE || dout.dest == CLS_CONTENT ||
                    dout.dest == CLS_TYPE))
        else $error("undefined class code on output");

    // words of one run follow without a gap and keep their class
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !dout.run_end) |=> (!empty && dout.dest == $past(dout.dest)))
        else $error("run broken or class changed inside a run");

endmodule

bind mail_header_class_splitter_core mhcs_checker u_mhcs_checker (.*);

`default_nettype wire
